@@ rtl/core/soa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab object allocator package
// Sizes, codes and control bundles shared by the allocator modules.
// ----------------------------------------------------------------------------
package soa_pkg;

   localparam int NUM_SLABS   = 16;
   localparam int SLOT_W      = 4;     // bits to index a slab
   localparam int SLAB_IDX_W  = 5;     // slab number with room for the null code
   localparam int SLAB_SHIFT  = 12;    // log2 of the slab size in bytes
   localparam int MAX_OBJECTS = 64;
   localparam int BIT_W       = 6;     // bits to index an object
   localparam int ADDR_W      = 32;
   localparam int OFF_W       = SLAB_SHIFT;
   localparam int SIZE_W      = 13;
   localparam int NOBJ_W      = 7;
   localparam int HDR_W       = 12;
   localparam int CNT_W       = 7;
   localparam int PROD_W      = BIT_W + SIZE_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SLAB_IDX_W-1:0] NIL_SLAB  = 5'd31;
   localparam logic [CNT_W-1:0]      CNT_MAX   = 7'd127;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SLAB   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD_FREE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OBJECT_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OBJECTS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER      = 2'd3;

   typedef struct packed {
      logic       load_req;
      logic       pick;
      logic       find;
      logic       alloc_upd;
      logic       walk;
      logic       check;
      logic       free_upd;
      logic       set_status;
      logic [1:0] status_code;
      logic       out_load;
   } soa_cmd_type;

   typedef struct packed {
      logic has_partial;
      logic has_empty;
      logic has_fresh;
      logic walk_hit;
      logic walk_end;
      logic below_header;
      logic div_done;
      logic out_free;
   } soa_stat_type;

endpackage

@@ rtl/core/soa_req_if.sv @@
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface soa_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] free_address;

   modport source (output valid, output operation, output free_address, input ready);
   modport sink   (input valid, input operation, input free_address, output ready);
endinterface

@@ rtl/core/soa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one status and object address.
// ----------------------------------------------------------------------------
interface soa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] object_address;

   modport source (output valid, output status, output object_address, input ready);
   modport sink   (input valid, input status, input object_address, output ready);
endinterface

@@ rtl/core/soa_div.sv @@
// ----------------------------------------------------------------------------
// Object number divider
// Restoring divider, one quotient bit per cycle, for (slab offset - header) / size.
// ----------------------------------------------------------------------------
module soa_div
   import soa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OFF_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic [OFF_W-1:0]  quotient,
   output logic              done
);

   localparam int CNT_W_DIV = $clog2(OFF_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W_DIV-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [OFF_W-1:0]     quo_ff, quo_in;
   logic [SIZE_W-1:0]    div_ff, div_in;
   logic [SIZE_W:0]      trial;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[OFF_W-1]};
      fits    = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SIZE_W'(trial - {1'b0, div_ff}) : trial[SIZE_W-1:0];
         quo_in = {quo_ff[OFF_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W_DIV'(OFF_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ rtl/core/soa_dpath.sv @@
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Slab tables, list heads, configuration, list walk and result register.
// ----------------------------------------------------------------------------
module soa_dpath
   import soa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  soa_cmd_type           cmd,
   output soa_stat_type          stat,
   input  logic [ADDR_W-1:0]     free_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [ADDR_W-1:0]     rsp_object_address
);

   logic [ADDR_W-1:0] pool_base_ff;
   logic [SIZE_W-1:0] object_size_ff;
   logic [NOBJ_W-1:0] objects_ff;
   logic [HDR_W-1:0]  header_ff;

   logic [MAX_OBJECTS-1:0] free_map_ff   [NUM_SLABS];
   logic [CNT_W-1:0]       free_count_ff [NUM_SLABS];
   logic [SLAB_IDX_W-1:0]  next_slab_ff  [NUM_SLABS];

   logic [SLAB_IDX_W-1:0] partial_head_ff, empty_head_ff, full_head_ff, fresh_count_ff;
   logic [SLAB_IDX_W-1:0] cur_ff, prev_ff, k_ff;
   logic                  in_partial_ff, from_partial_ff, found_ff;
   logic [ADDR_W-1:0]     addr_ff, obj_addr_ff;
   logic [1:0]            status_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;

   logic [NOBJ_W-1:0]  eff_n;
   logic [SIZE_W-1:0]  eff_size;
   logic [SLOT_W-1:0]  slot, fresh_slot, prev_slot;
   logic               cur_valid, prev_valid, walk_live;
   logic [ADDR_W-1:0]  cur_start, walk_off;
   logic [MAX_OBJECTS-1:0] cur_map;
   logic [CNT_W-1:0]   cur_cnt, dec_cnt, inc_cnt;
   logic [BIT_W-1:0]   low_bit;
   logic               low_found;
   logic [OFF_W-1:0]   quotient;
   logic               div_done;
   logic               num_bad;

   assign eff_n = (objects_ff == '0) ? NOBJ_W'(1) :
                  (objects_ff > NOBJ_W'(MAX_OBJECTS)) ? NOBJ_W'(MAX_OBJECTS) : objects_ff;
   assign eff_size   = (object_size_ff == '0) ? SIZE_W'(1) : object_size_ff;
   assign slot       = cur_ff[SLOT_W-1:0];
   assign fresh_slot = fresh_count_ff[SLOT_W-1:0];
   assign prev_slot  = prev_ff[SLOT_W-1:0];
   assign cur_valid  = cur_ff < SLAB_IDX_W'(NUM_SLABS);
   assign prev_valid = prev_ff < SLAB_IDX_W'(NUM_SLABS);
   assign cur_start  = pool_base_ff + (ADDR_W'(slot) << SLAB_SHIFT);
   assign walk_off   = addr_ff - cur_start;
   assign walk_live  = cur_valid && (k_ff < SLAB_IDX_W'(NUM_SLABS));
   assign cur_map    = free_map_ff[slot];
   assign cur_cnt    = free_count_ff[slot];
   assign dec_cnt    = (cur_cnt != '0) ? cur_cnt - 1'b1 : cur_cnt;
   assign inc_cnt    = (cur_cnt < CNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
   assign num_bad    = (quotient >= OFF_W'(eff_n)) || !cur_map[quotient[BIT_W-1:0]];

   // lowest clear bit of the chosen slab's map
   always_comb begin
      low_bit   = '0;
      low_found = 1'b0;
      for (int j = MAX_OBJECTS - 1; j >= 0; j--) begin
         if (!cur_map[j]) begin
            low_bit   = BIT_W'(j);
            low_found = 1'b1;
         end
      end
   end

   soa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.check),
      .dividend (off_ff - header_ff),
      .divisor  (eff_size),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      stat.has_partial  = partial_head_ff < SLAB_IDX_W'(NUM_SLABS);
      stat.has_empty    = empty_head_ff < SLAB_IDX_W'(NUM_SLABS);
      stat.has_fresh    = fresh_count_ff < SLAB_IDX_W'(NUM_SLABS);
      stat.walk_hit     = walk_live && (walk_off[ADDR_W-1:OFF_W] == '0) && (walk_off != '0);
      stat.walk_end     = !walk_live && !in_partial_ff;
      stat.below_header = off_ff < header_ff;
      stat.div_done     = div_done;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         object_size_ff <= SIZE_W'(64);
         objects_ff     <= NOBJ_W'(32);
         header_ff      <= HDR_W'(64);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_POOL_BASE:   pool_base_ff   <= csr_write_data[ADDR_W-1:0];
            REG_OBJECT_SIZE: object_size_ff <= csr_write_data[SIZE_W-1:0];
            REG_OBJECTS:     objects_ff     <= csr_write_data[NOBJ_W-1:0];
            REG_HEADER:      header_ff      <= csr_write_data[HDR_W-1:0];
            default: ;
         endcase
      end
   end

   // list heads and fresh count
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_head_ff <= NIL_SLAB;
         empty_head_ff   <= NIL_SLAB;
         full_head_ff    <= NIL_SLAB;
         fresh_count_ff  <= '0;
      end else begin
         if (cmd.pick && !stat.has_partial && !stat.has_empty) begin
            empty_head_ff  <= fresh_count_ff;
            fresh_count_ff <= fresh_count_ff + 1'b1;
         end
         if (cmd.alloc_upd && found_ff) begin
            if (from_partial_ff) begin
               if (dec_cnt == '0) begin
                  partial_head_ff <= next_slab_ff[slot];
                  full_head_ff    <= cur_ff;
               end
            end else begin
               empty_head_ff <= next_slab_ff[slot];
               if (dec_cnt == '0) full_head_ff <= cur_ff;
               else partial_head_ff <= cur_ff;
            end
         end
         if (cmd.free_upd && !num_bad) begin
            if (!in_partial_ff && !prev_valid) full_head_ff <= next_slab_ff[slot];
            if (inc_cnt >= CNT_W'(eff_n)) begin
               if (in_partial_ff && !prev_valid) partial_head_ff <= next_slab_ff[slot];
               empty_head_ff <= cur_ff;
            end else if (!in_partial_ff) begin
               partial_head_ff <= cur_ff;
            end
         end
      end
   end

   // slab tables
   always_ff @(posedge clock) begin
      if (cmd.pick && !stat.has_partial && !stat.has_empty) begin
         free_map_ff[fresh_slot]   <= (eff_n >= NOBJ_W'(MAX_OBJECTS)) ? '0 :
                                      ({MAX_OBJECTS{1'b1}} << eff_n);
         free_count_ff[fresh_slot] <= CNT_W'(eff_n);
         next_slab_ff[fresh_slot]  <= empty_head_ff;
      end
      if (cmd.alloc_upd && found_ff) begin
         free_map_ff[slot]   <= cur_map | (MAX_OBJECTS'(1) << bit_ff);
         free_count_ff[slot] <= dec_cnt;
         if (dec_cnt == '0) begin
            if (!from_partial_ff || (dec_cnt == '0)) next_slab_ff[slot] <= full_head_ff;
         end else if (!from_partial_ff) begin
            next_slab_ff[slot] <= partial_head_ff;
         end
      end
      if (cmd.free_upd && !num_bad) begin
         free_map_ff[slot]   <= cur_map & ~(MAX_OBJECTS'(1) << quotient[BIT_W-1:0]);
         free_count_ff[slot] <= inc_cnt;
         // unlink through the predecessor
         if (prev_valid && (!in_partial_ff || (inc_cnt >= CNT_W'(eff_n))))
            next_slab_ff[prev_slot] <= next_slab_ff[slot];
         if (inc_cnt >= CNT_W'(eff_n)) next_slab_ff[slot] <= empty_head_ff;
         else if (!in_partial_ff) next_slab_ff[slot] <= partial_head_ff;
      end
   end

   // walk, selection and result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= obj_addr_ff;
      end
      if (cmd.load_req) begin
         addr_ff       <= free_address;
         cur_ff        <= partial_head_ff;
         prev_ff       <= NIL_SLAB;
         k_ff          <= '0;
         in_partial_ff <= 1'b1;
         obj_addr_ff   <= '0;
         status_ff     <= ST_OK;
      end
      if (cmd.set_status) status_ff <= cmd.status_code;
      if (cmd.pick) begin
         if (stat.has_partial) begin
            cur_ff          <= partial_head_ff;
            from_partial_ff <= 1'b1;
         end else begin
            cur_ff          <= stat.has_empty ? empty_head_ff : fresh_count_ff;
            from_partial_ff <= 1'b0;
         end
      end
      if (cmd.find) begin
         bit_ff   <= low_bit;
         found_ff <= low_found;
         prod_ff  <= PROD_W'(low_bit) * PROD_W'(eff_size);
      end
      if (cmd.alloc_upd) begin
         if (found_ff) obj_addr_ff <= cur_start + ADDR_W'(header_ff) + ADDR_W'(prod_ff);
         else status_ff <= ST_NO_SLAB;
      end
      if (cmd.walk) begin
         if (stat.walk_hit) begin
            off_ff <= walk_off[OFF_W-1:0];
         end else if (!walk_live) begin
            cur_ff        <= full_head_ff;
            prev_ff       <= NIL_SLAB;
            k_ff          <= '0;
            in_partial_ff <= 1'b0;
         end else begin
            prev_ff <= cur_ff;
            cur_ff  <= next_slab_ff[slot];
            k_ff    <= k_ff + 1'b1;
         end
      end
      if (cmd.free_upd && num_bad) status_ff <= ST_BAD_FREE;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_object_address = rsp_addr_ff;

endmodule

@@ rtl/core/soa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences allocate and free requests through the datapath.
// ----------------------------------------------------------------------------
module soa_ctrl
   import soa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_operation,
   output logic         req_ready,
   input  soa_stat_type stat,
   output soa_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_A_PICK = 4'd1;
   localparam logic [3:0] S_A_FIND = 4'd2;
   localparam logic [3:0] S_A_UPD  = 4'd3;
   localparam logic [3:0] S_F_WALK = 4'd4;
   localparam logic [3:0] S_F_CHK  = 4'd5;
   localparam logic [3:0] S_F_DIV  = 4'd6;
   localparam logic [3:0] S_F_UPD  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_operation == OP_FREE) ? S_F_WALK : S_A_PICK;
            end
         end
         S_A_PICK: begin
            if (stat.has_partial || stat.has_empty || stat.has_fresh) begin
               cmd.pick = 1'b1;
               state_in = S_A_FIND;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NO_SLAB;
               state_in        = S_DONE;
            end
         end
         S_A_FIND: begin
            cmd.find = 1'b1;
            state_in = S_A_UPD;
         end
         S_A_UPD: begin
            cmd.alloc_upd = 1'b1;
            state_in      = S_DONE;
         end
         S_F_WALK: begin
            if (stat.walk_hit) begin
               cmd.walk = 1'b1;
               state_in = S_F_CHK;
            end else if (stat.walk_end) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = S_DONE;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         S_F_CHK: begin
            if (stat.below_header) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_BAD_FREE;
               state_in        = S_DONE;
            end else begin
               cmd.check = 1'b1;
               state_in  = S_F_DIV;
            end
         end
         S_F_DIV: begin
            if (stat.div_done) state_in = S_F_UPD;
         end
         S_F_UPD: begin
            cmd.free_upd = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

@@ rtl/core/slab_object_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Slab object allocator
// Hands out and takes back fixed-size objects from a pool of slabs.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan: operation 0 allocates, 1 frees free_address.
// Each request yields exactly one transfer on rsp_chan with a status and,
// for a successful allocate, the object address.
// One request is in work at a time. An allocate picks a slab, finds a
// free object and updates the lists, or stops after the pick when no slab
// is left. A free walks the partial, then the full list one slab per cycle
// (16 slabs in all), then runs a shift-subtract divider for the object
// number. The list walk and the divider set the free latency.
// Configuration writes on csr_* are registered; write only while idle.
// Reset empties all lists, marks every slab unused and restores the
// default registers. A stalled result stays in the output register; the
// next request is taken and worked on, and its result waits until the
// output register is free.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit
   import soa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   soa_req_if.sink               req_chan,
   soa_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   soa_cmd_type  cmd;
   soa_stat_type stat;

   soa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   soa_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .stat               (stat),
      .free_address       (req_chan.free_address),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_object_address (rsp_chan.object_address)
   );

endmodule
